### rtl/particle_euler_integrator_macros.svh
// Assertion macros shared by the particle integrator RTL.
`ifndef PARTICLE_EULER_INTEGRATOR_MACROS_SVH
`define PARTICLE_EULER_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define PEI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define PEI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pei_pkg.sv
// Types and constants of the particle Euler integrator.
`timescale 1ns / 1ps
`default_nettype none

package pei_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int STEP_FRAC = 16;
  localparam int DRAG_FRAC = 16;
  localparam int DT_BITS   = 16;
  localparam int DRAG_BITS = 17;
  localparam int AXES      = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [1:0] op_t;

  localparam op_t OP_FORCE = 2'd0;
  localparam op_t OP_STEP  = 2'd1;
  localparam op_t OP_LOAD  = 2'd2;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_INV_MASS = 3'd0;
  localparam cfg_idx_t CFG_DRAG     = 3'd1;
  localparam cfg_idx_t CFG_ACCEL_X  = 3'd2;
  localparam cfg_idx_t CFG_ACCEL_Y  = 3'd3;
  localparam cfg_idx_t CFG_ACCEL_Z  = 3'd4;

  localparam logic [DRAG_BITS-1:0] DRAG_RESET = 17'd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RND,
    S_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    STEP_POS,
    STEP_ACC,
    STEP_VEL,
    STEP_DRAG
  } step_t;

  typedef struct packed {
    op_t                op;
    word_t              force_x;
    word_t              force_y;
    word_t              force_z;
    logic [DT_BITS-1:0] time_step;
    word_t              load_pos_x;
    word_t              load_pos_y;
    word_t              load_pos_z;
    word_t              load_vel_x;
    word_t              load_vel_y;
    word_t              load_vel_z;
  } in_item_t;

  typedef struct packed {
    word_t out_pos_x;
    word_t out_pos_y;
    word_t out_pos_z;
    word_t out_vel_x;
    word_t out_vel_y;
    word_t out_vel_z;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/particle_euler_integrator.sv
// Particle Euler integrator: one particle's position, velocity and force sum in Q16.16.
// Sequence: a force, load or unused-op item, or a step with zero inverse mass, goes from
// idle straight to the done state; a step runs on the shared multiplier (3 axes x 4 products,
// each in multiply, round and add states) before done. The result is registered once out is free.
// The next item is taken once the result is registered; none is taken while one is in progress.
// Reset (rst_n low, synchronous) clears all vectors, inverse mass and acceleration; drag 1.0.
`timescale 1ns / 1ps
`default_nettype none

`include "particle_euler_integrator_macros.svh"

module particle_euler_integrator (
  input  wire                    clk,
  input  wire                    rst_n,
  // Input item channel.
  input  wire                    in_valid,
  output logic                   in_stall,
  input  pei_pkg::in_item_t      in_item,
  // Result item channel.
  output logic                   out_valid,
  input  wire                    out_stall,
  output pei_pkg::out_item_t     out_item,
  // Configuration write channel.
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [2:0]             cfg_index,
  input  wire  [31:0]            cfg_data
);

  import pei_pkg::*;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam logic [PROD_BITS-1:0] HALF_F = PROD_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_BITS-1:0] HALF_S = PROD_BITS'(1) << (STEP_FRAC - 1);
  localparam logic [PROD_BITS-1:0] HALF_D = PROD_BITS'(1) << (DRAG_FRAC - 1);
  localparam logic [WORD_BITS-1:0] LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  // Signed add that saturates to the word range.
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    begin
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
        sat_add = s[WORD_BITS] ? word_t'(LIM_NEG) : word_t'(LIM_POS);
      end else begin
        sat_add = s[WORD_BITS-1:0];
      end
    end
  endfunction

  // Configuration registers.
  logic [WORD_BITS-1:0] inv_mass_r;
  logic [DRAG_BITS-1:0] drag_r;
  word_t                accel_r [AXES];

  // Particle state.
  word_t pos_r [AXES];
  word_t vel_r [AXES];
  word_t fs_r  [AXES];

  // Sequencer.
  state_t     state_r, state_nxt;
  step_t      step_r, step_nxt;
  logic [1:0] axis_r, axis_nxt;

  // Shared multiply, round and add unit.
  logic [DT_BITS-1:0]   dt_r;
  logic [PROD_BITS-1:0] prod_r;
  logic                 neg_r;
  word_t                mres_r;
  word_t                tmp_r;

  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic in_accept;
  logic out_free;
  logic out_load;

  word_t force_in [AXES];

  word_t                a_sel;
  logic [WORD_BITS-1:0] a_u;
  logic [WORD_BITS-1:0] a_mag;
  logic [WORD_BITS-1:0] m_sel;

  logic [PROD_BITS-1:0] rnd;
  logic [WORD_BITS-1:0] lim;
  logic [WORD_BITS-1:0] mag_sat;
  word_t                mres_nxt;
  word_t                addend;
  word_t                sum;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign force_in[0] = in_item.force_x;
  assign force_in[1] = in_item.force_y;
  assign force_in[2] = in_item.force_z;

  // Next state of the sequencer and its axis and step counters.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          step_nxt = STEP_POS;
          axis_nxt = 2'd0;
          // An integrate step with infinite mass leaves everything as it is.
          if (in_item.op == OP_STEP && inv_mass_r != '0) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL: state_nxt = S_RND;
      S_RND: state_nxt = S_ADD;
      S_ADD: begin
        if (step_r == STEP_DRAG) begin
          step_nxt = STEP_POS;
          axis_nxt = (axis_r == LAST_AXIS) ? 2'd0 : axis_r + 2'd1;
          state_nxt = (axis_r == LAST_AXIS) ? S_DONE : S_MUL;
        end else begin
          step_nxt  = step_t'(step_r + 2'd1);
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and load controls decoded from the state.
  always_comb begin
    in_stall = (state_r != S_IDLE);
    out_load = (state_r == S_DONE) && out_free;
  end

  // Operand selection for the multiplier. Each axis runs four products in turn:
  // velocity times step, force sum times inverse mass, acceleration times step,
  // and the new velocity times drag.
  always_comb begin
    unique case (step_r)
      STEP_POS: begin
        a_sel = vel_r[axis_r];
        m_sel = {{(WORD_BITS-DT_BITS){1'b0}}, dt_r};
      end
      STEP_ACC: begin
        a_sel = fs_r[axis_r];
        m_sel = inv_mass_r;
      end
      STEP_VEL: begin
        a_sel = tmp_r;
        m_sel = {{(WORD_BITS-DT_BITS){1'b0}}, dt_r};
      end
      STEP_DRAG: begin
        a_sel = tmp_r;
        m_sel = {{(WORD_BITS-DRAG_BITS){1'b0}}, drag_r};
      end
      default: begin
        a_sel = '0;
        m_sel = '0;
      end
    endcase
    a_u   = a_sel;
    a_mag = a_u[WORD_BITS-1] ? (~a_u + 1'b1) : a_u;
  end

  // Round the product magnitude to nearest (ties away from zero), saturate, restore sign.
  always_comb begin
    unique case (step_r)
      STEP_ACC:  rnd = (prod_r + HALF_F) >> FRAC_BITS;
      STEP_DRAG: rnd = (prod_r + HALF_D) >> DRAG_FRAC;
      default:   rnd = (prod_r + HALF_S) >> STEP_FRAC;
    endcase
    lim      = neg_r ? LIM_NEG : LIM_POS;
    mag_sat  = (rnd > {{WORD_BITS{1'b0}}, lim}) ? lim : rnd[WORD_BITS-1:0];
    mres_nxt = neg_r ? word_t'(~mag_sat + 1'b1) : word_t'(mag_sat);
  end

  // Saturating add of the rounded product and the term that belongs to this step.
  always_comb begin
    unique case (step_r)
      STEP_POS:  addend = pos_r[axis_r];
      STEP_ACC:  addend = accel_r[axis_r];
      STEP_VEL:  addend = vel_r[axis_r];
      STEP_DRAG: addend = '0;
      default:   addend = '0;
    endcase
    sum = sat_add(mres_r, addend);
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_POS;
      axis_r      <= 2'd0;
      out_valid_r <= 1'b0;
      inv_mass_r  <= '0;
      drag_r      <= DRAG_RESET;
      for (int i = 0; i < AXES; i++) begin
        accel_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_INV_MASS: inv_mass_r <= cfg_data;
          CFG_DRAG:     drag_r     <= cfg_data[DRAG_BITS-1:0];
          CFG_ACCEL_X:  accel_r[0] <= cfg_data;
          CFG_ACCEL_Y:  accel_r[1] <= cfg_data;
          CFG_ACCEL_Z:  accel_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Particle state: direct updates at acceptance, results of the shared unit in the add phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        fs_r[i]  <= '0;
      end
    end else begin
      if (in_accept) begin
        unique case (in_item.op)
          OP_FORCE: begin
            for (int i = 0; i < AXES; i++) begin
              fs_r[i] <= sat_add(fs_r[i], force_in[i]);
            end
          end
          OP_LOAD: begin
            pos_r[0] <= in_item.load_pos_x;
            pos_r[1] <= in_item.load_pos_y;
            pos_r[2] <= in_item.load_pos_z;
            vel_r[0] <= in_item.load_vel_x;
            vel_r[1] <= in_item.load_vel_y;
            vel_r[2] <= in_item.load_vel_z;
          end
          default: ;
        endcase
      end
      if (state_r == S_ADD) begin
        unique case (step_r)
          STEP_POS: pos_r[axis_r] <= sum;
          STEP_DRAG: begin
            vel_r[axis_r] <= sum;
            fs_r[axis_r]  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers of the shared unit and the result register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      dt_r <= in_item.time_step;
    end
    if (state_r == S_MUL) begin
      prod_r <= {{WORD_BITS{1'b0}}, a_mag} * {{WORD_BITS{1'b0}}, m_sel};
      neg_r  <= a_sel[WORD_BITS-1];
    end
    if (state_r == S_RND) begin
      mres_r <= mres_nxt;
    end
    if (state_r == S_ADD && (step_r == STEP_ACC || step_r == STEP_VEL)) begin
      tmp_r <= sum;
    end
    if (out_load) begin
      out_item_r.out_pos_x <= pos_r[0];
      out_item_r.out_pos_y <= pos_r[1];
      out_item_r.out_pos_z <= pos_r[2];
      out_item_r.out_vel_x <= vel_r[0];
      out_item_r.out_vel_y <= vel_r[1];
      out_item_r.out_vel_z <= vel_r[2];
    end
  end

  `PEI_ASSERT_NXT(a_step_starts, in_accept && in_item.op == OP_STEP && inv_mass_r != '0, state_r == S_MUL && step_r == STEP_POS && axis_r == 2'd0, "integrate item did not start the sequencer")
  `PEI_ASSERT_NXT(a_direct_done, in_accept && in_item.op != OP_STEP, state_r == S_DONE, "direct item did not go straight to completion")
  `PEI_ASSERT_NXT(a_last_add_done, state_r == S_ADD && step_r == STEP_DRAG && axis_r == LAST_AXIS, state_r == S_DONE, "sequencer ran past the last axis")
  `PEI_ASSERT_NXT(a_done_shows, state_r == S_DONE && !out_valid_r, out_valid_r, "finished item was not presented")
  `PEI_ASSERT_IMP(a_axis_range, state_r != S_IDLE, axis_r <= LAST_AXIS, "axis counter out of range")

endmodule

`default_nettype wire
